FILE: src/rtmc_pkg.sv
`default_nettype none

package rtmc_pkg;

    // Route store geometry.
    localparam int ROUTE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(ROUTE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    // Code and configuration widths.
    localparam int CODE_W  = 10;
    localparam int CFG_IDX_W = 2;

    // Turn codes and their merged large-turn forms.
    localparam logic [CODE_W-1:0] TURN_RIGHT     = 10'd300;
    localparam logic [CODE_W-1:0] TURN_LEFT      = 10'd400;
    localparam logic [CODE_W-1:0] BIG_RIGHT_ONE  = 10'd501;
    localparam logic [CODE_W-1:0] BIG_RIGHT_TWO  = 10'd502;
    localparam logic [CODE_W-1:0] BIG_LEFT_ONE   = 10'd601;
    localparam logic [CODE_W-1:0] BIG_LEFT_TWO   = 10'd602;
    localparam logic [CODE_W-1:0] CODE_NONE      = 10'd0;

    // Configuration reset values.
    localparam logic [CODE_W-1:0] STRAIGHT_RESET = 10'd200;
    localparam logic [CODE_W-1:0] BOUND_RESET    = 10'd300;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRAIGHT = 2'd0,
        CFG_BOUND    = 2'd1
    } t_cfg_idx;

    // Control states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_STEP,
        S_EMIT_RD,
        S_EMIT_CHK,
        S_SINGLE
    } t_state;

    // One input transaction.
    typedef struct packed {
        logic [CODE_W-1:0] move_code;
        logic              final_item;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [CODE_W-1:0] out_code;
        logic              last_out;
        logic              route_empty;
        logic              route_overflow;
    } t_out_item;

endpackage

`default_nettype wire

FILE: src/route_turn_merge_compactor.sv
// Loads one code per cycle; the input stalls from the ending transaction until the last
// result of that route sits in the output register.
// Each walk position runs one fetch state per code consumed, one more to land the last read,
// and then a step state; emission reads and then checks each merged entry.
// Synchronous active-low reset clears control state and sets straight_code 200, turn_bound 300.
// Both stores are left unwritten by reset.
`default_nettype none

module route_turn_merge_compactor
    import rtmc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CODE_W-1:0]     i_cfg_data
);

    // Straight test against the configured window.
    function automatic logic straight_f(input logic [CODE_W-1:0] c,
                                        input logic [CODE_W-1:0] lo,
                                        input logic [CODE_W-1:0] hi);
        return (c > lo) && (c < hi);
    endfunction

    t_state r_state, n_state;

    logic [CODE_W-1:0] r_route_mem  [ROUTE_DEPTH];
    logic [CODE_W-1:0] r_merged_mem [ROUTE_DEPTH];

    logic [CODE_W-1:0] r_straight, r_bound;
    logic [CNT_W-1:0]  r_count, n_count, r_len, n_len;
    logic [CNT_W-1:0]  r_i, n_i, r_j, n_j, r_fa, n_fa, r_k, n_k, r_last, n_last;
    logic [1:0]        r_need, n_need, r_slot, n_slot;
    logic              r_pend, n_pend, r_any, n_any, r_ovf, n_ovf;
    logic              r_out_valid, n_out_valid;
    logic [CODE_W-1:0] r_win [3];
    logic [CODE_W-1:0] n_win [3];
    logic [CODE_W-1:0] r_prev, n_prev, r_mlast, n_mlast;
    logic [CODE_W-1:0] r_rdata, r_mdata;
    t_out_item         r_out, n_out;

    logic              w_rt_we, w_mg_we;
    logic [ADDR_W-1:0] w_rt_waddr, w_mg_waddr;
    logic [CODE_W-1:0] w_rt_wdata, w_mg_wdata;

    logic              w_in_acc, w_store, w_finish, w_out_free;
    logic [CNT_W-1:0]  w_len_now, w_span_end;
    logic              w_turn, w_pair, w_merge, w_walk_end, w_any_final;
    logic [CODE_W-1:0] w_after, w_new_code, w_commit;

    // Handshake outputs.
    assign o_in_stall  = (r_state != S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Load-side decisions.
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_store    = (i_in_data.move_code != CODE_NONE) && (r_count < CNT_W'(ROUTE_DEPTH));
    assign w_finish   = (i_in_data.move_code == CODE_NONE) || i_in_data.final_item;
    assign w_len_now  = w_store ? (r_count + CNT_W'(1)) : r_count;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Walk-step decisions over the window at positions i, i+1, i+2.
    assign w_turn     = (r_win[0] == TURN_RIGHT) || (r_win[0] == TURN_LEFT);
    assign w_pair     = w_turn && ((r_i + CNT_W'(1)) < r_len) && (r_win[1] == r_win[0]);
    assign w_after    = w_pair ? r_win[2] : r_win[1];
    assign w_span_end = r_i + (w_pair ? CNT_W'(2) : CNT_W'(1));
    assign w_merge    = w_turn && (r_i != '0) && (r_j != '0) && (w_span_end < r_len)
                        && straight_f(r_prev, r_straight, r_bound)
                        && straight_f(w_after, r_straight, r_bound);
    assign w_new_code = (r_win[0] == TURN_RIGHT) ? (w_pair ? BIG_RIGHT_TWO : BIG_RIGHT_ONE)
                                                 : (w_pair ? BIG_LEFT_TWO : BIG_LEFT_ONE);
    assign w_commit    = w_merge ? (r_mlast - CODE_W'(1)) : r_mlast;
    assign w_walk_end  = (r_i >= r_len);
    assign w_any_final = r_any || ((r_j != '0) && (r_mlast != r_straight));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_straight <= STRAIGHT_RESET;
            r_bound    <= BOUND_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STRAIGHT: r_straight <= i_cfg_data;
                CFG_BOUND:    r_bound    <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && w_finish) begin
                    n_state = (w_len_now == CNT_W'(ROUTE_DEPTH)) ? S_SINGLE : S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_need == 2'd0) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (w_walk_end) begin
                    n_state = w_any_final ? S_EMIT_RD : S_SINGLE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_EMIT_RD: n_state = S_EMIT_CHK;
            S_EMIT_CHK: begin
                if (r_mdata == r_straight) begin
                    n_state = S_EMIT_RD;
                end else if (w_out_free) begin
                    n_state = (r_k == r_last) ? S_LOAD : S_EMIT_RD;
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Datapath and memory controls per state.
    always_comb begin
        n_count     = r_count;
        n_len       = r_len;
        n_i         = r_i;
        n_j         = r_j;
        n_fa        = r_fa;
        n_k         = r_k;
        n_last      = r_last;
        n_need      = r_need;
        n_slot      = r_slot;
        n_pend      = r_pend;
        n_any       = r_any;
        n_ovf       = r_ovf;
        n_win       = r_win;
        n_prev      = r_prev;
        n_mlast     = r_mlast;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_rt_we     = 1'b0;
        w_rt_waddr  = r_count[ADDR_W-1:0];
        w_rt_wdata  = i_in_data.move_code;
        w_mg_we     = 1'b0;
        w_mg_waddr  = r_j[ADDR_W-1:0] - ADDR_W'(1);
        w_mg_wdata  = w_commit;

        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_store) begin
                        w_rt_we = 1'b1;
                        n_count = w_len_now;
                    end
                    if (w_finish) begin
                        n_count = '0;
                        n_len   = w_len_now;
                        n_i     = '0;
                        n_j     = '0;
                        n_fa    = '0;
                        n_need  = 2'd3;
                        n_slot  = 2'd0;
                        n_pend  = 1'b0;
                        n_any   = 1'b0;
                        n_ovf   = (w_len_now == CNT_W'(ROUTE_DEPTH));
                    end
                end
            end
            S_FETCH: begin
                // Land the previous read, issue the next one.
                if (r_pend) begin
                    for (int s = 0; s < 3; s++) begin
                        if (r_slot == 2'(s)) begin
                            n_win[s] = r_rdata;
                        end
                    end
                    n_slot = r_slot + 2'd1;
                end
                if (r_need != 2'd0) begin
                    n_pend = 1'b1;
                    n_fa   = r_fa + CNT_W'(1);
                    n_need = r_need - 2'd1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_STEP: begin
                if (w_walk_end) begin
                    // Flush the held merged entry and settle the last kept index.
                    if (r_j != '0) begin
                        w_mg_we    = 1'b1;
                        w_mg_wdata = r_mlast;
                        if (r_mlast != r_straight) begin
                            n_last = r_j - CNT_W'(1);
                        end
                    end
                    n_any = w_any_final;
                    n_k   = '0;
                end else begin
                    // Commit the previous merged entry, which is now final.
                    if (r_j != '0) begin
                        w_mg_we = 1'b1;
                        if (w_commit != r_straight) begin
                            n_any  = 1'b1;
                            n_last = r_j - CNT_W'(1);
                        end
                    end
                    n_prev = r_win[0];
                    n_j    = r_j + CNT_W'(1);
                    if (w_merge) begin
                        n_mlast = w_new_code;
                        n_i     = w_span_end;
                        if (w_pair) begin
                            n_win[0] = r_win[2] - CODE_W'(1);
                            n_need   = 2'd2;
                            n_slot   = 2'd1;
                        end else begin
                            n_win[0] = r_win[1] - CODE_W'(1);
                            n_win[1] = r_win[2];
                            n_need   = 2'd1;
                            n_slot   = 2'd2;
                        end
                    end else begin
                        n_mlast  = r_win[0];
                        n_i      = r_i + CNT_W'(1);
                        n_win[0] = r_win[1];
                        n_win[1] = r_win[2];
                        n_need   = 2'd1;
                        n_slot   = 2'd2;
                    end
                end
            end
            S_EMIT_RD: ;
            S_EMIT_CHK: begin
                // Drop entries that fell to a bare straight.
                if (r_mdata == r_straight) begin
                    n_k = r_k + CNT_W'(1);
                end else if (w_out_free) begin
                    n_out.out_code       = r_mdata;
                    n_out.last_out       = (r_k == r_last);
                    n_out.route_empty    = 1'b0;
                    n_out.route_overflow = 1'b0;
                    n_out_valid          = 1'b1;
                    n_k                  = r_k + CNT_W'(1);
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    n_out.out_code       = CODE_NONE;
                    n_out.last_out       = 1'b1;
                    n_out.route_empty    = !r_ovf;
                    n_out.route_overflow = r_ovf;
                    n_out_valid          = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_len       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_fa        <= '0;
            r_k         <= '0;
            r_last      <= '0;
            r_need      <= '0;
            r_slot      <= '0;
            r_pend      <= 1'b0;
            r_any       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_len       <= n_len;
            r_i         <= n_i;
            r_j         <= n_j;
            r_fa        <= n_fa;
            r_k         <= n_k;
            r_last      <= n_last;
            r_need      <= n_need;
            r_slot      <= n_slot;
            r_pend      <= n_pend;
            r_any       <= n_any;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_win   <= n_win;
        r_prev  <= n_prev;
        r_mlast <= n_mlast;
        r_out   <= n_out;
    end

    // Route store: written while loading, read sequentially during the walk.
    always_ff @(posedge i_clk) begin
        if (w_rt_we) begin
            r_route_mem[w_rt_waddr] <= w_rt_wdata;
        end
        r_rdata <= r_route_mem[r_fa[ADDR_W-1:0]];
    end

    // Merged store: written during the walk, read sequentially during emission.
    always_ff @(posedge i_clk) begin
        if (w_mg_we) begin
            r_merged_mem[w_mg_waddr] <= w_mg_wdata;
        end
        r_mdata <= r_merged_mem[r_k[ADDR_W-1:0]];
    end

endmodule

`default_nettype wire
